// ===== design/rmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rmf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int PIX_W          = 24;
	localparam int CFG_W          = 13;
	localparam int WIDTH_REG_W    = 11;
	localparam int HEIGHT_REG_W   = 13;
	localparam int RESET_WIDTH    = 256;
	localparam int RESET_HEIGHT   = 256;

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef logic [PIX_W-1:0] rgb_t;
	typedef rgb_t [8:0] win_t;

	typedef struct packed {
		logic run_last;
		logic frame_last;
	} tag_t;

endpackage
`default_nettype wire

// ===== design/rmf_line_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmf_line_ram #(
	parameter int DEPTH = rmf_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(rmf_pkg::MAX_WIDTH_DEF)
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output rmf_pkg::rgb_t      rdata,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire rmf_pkg::rgb_t wdata
);

	rmf_pkg::rgb_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/rmf_median9.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmf_median9 (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire rmf_pkg::win_t win,
	input  wire rmf_pkg::tag_t in_tag,
	output logic               out_valid,
	output rmf_pkg::rgb_t      out_px,
	output rmf_pkg::tag_t      out_tag
);

	function automatic logic [7:0] mn(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [7:0] mx(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [7:0] md3(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		return mx(mn(a, b), mn(mx(a, b), c));
	endfunction

	// sorted rows: [channel][row][0 lo, 1 mid, 2 hi]
	logic [7:0] srt_c  [3][3][3];
	logic [7:0] srt_s1 [3][3][3];
	logic       v_s1;
	rmf_pkg::tag_t tag_s1;

	logic [7:0] lo_s2 [3];
	logic [7:0] md_s2 [3];
	logic [7:0] hi_s2 [3];
	logic       v_s2;
	rmf_pkg::tag_t tag_s2;

	logic       out_valid_q;
	logic [7:0] med_q [3];
	rmf_pkg::tag_t tag_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				srt_c[ch][r][0] = mn(mn(win[r*3][8*(2-ch) +: 8], win[r*3+1][8*(2-ch) +: 8]),
					win[r*3+2][8*(2-ch) +: 8]);
				srt_c[ch][r][1] = md3(win[r*3][8*(2-ch) +: 8], win[r*3+1][8*(2-ch) +: 8],
					win[r*3+2][8*(2-ch) +: 8]);
				srt_c[ch][r][2] = mx(mx(win[r*3][8*(2-ch) +: 8], win[r*3+1][8*(2-ch) +: 8]),
					win[r*3+2][8*(2-ch) +: 8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srt_s1 <= srt_c;
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_q  <= tag_s2;
			for (int ch = 0; ch < 3; ch++) begin
				lo_s2[ch] <= mx(mx(srt_s1[ch][0][0], srt_s1[ch][1][0]), srt_s1[ch][2][0]);
				md_s2[ch] <= md3(srt_s1[ch][0][1], srt_s1[ch][1][1], srt_s1[ch][2][1]);
				hi_s2[ch] <= mn(mn(srt_s1[ch][0][2], srt_s1[ch][1][2]), srt_s1[ch][2][2]);
				med_q[ch] <= md3(lo_s2[ch], md_s2[ch], hi_s2[ch]);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_px    = {med_q[0], med_q[1], med_q[2]};
	assign out_tag   = tag_q;

endmodule
`default_nettype wire

// ===== design/rgb_median_3x3_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// streaming 3x3 rgb median filter. pixels come in raster order, one transaction per clock
// when not stalled; each pixel reads and rewrites one column of two line rams (registered
// read) and the separate red, green and blue medians of nine come out of a fixed three-stage
// network, the result going through stage 1, stage 2 and the network registers. a pixel that
// yields two results (last column of every row after the first) holds the input while its
// second result is handed on. when the last pixel of the frame has gone in, the block takes
// no transaction while stage 1 empties and it preloads column 0 of the line rams; drain
// transactions then flush the final row at one per clock when not stalled. pixels that arrive
// while the final row drains, and drains outside that phase, are taken with no result. any
// configuration write restarts the frame position.
module rgb_median_3x3_filter_top #(
	parameter int MAX_WIDTH  = rmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rmf_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [rmf_pkg::CFG_W-1:0]  cfg_data,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       opcode,
	input  wire logic [7:0]                 in_red,
	input  wire logic [7:0]                 in_green,
	input  wire logic [7:0]                 in_blue,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic                            run_last,
	output logic                            frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// preload sequencer codes
	localparam logic [1:0] PF_IDLE = 2'd0;
	localparam logic [1:0] PF_WAIT = 2'd1;
	localparam logic [1:0] PF_LOAD = 2'd2;

	// configuration registers
	logic [rmf_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [rmf_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [31:0] wx, hx;
	logic [WW-1:0] w_eff, w_m1;
	logic [HW-1:0] h_m1;

	// frame position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] drn_q;
	logic          flush_q;
	logic [1:0]    pf_q;

	// handshake
	logic go, up_adv, acc, is_pix, is_drn;
	logic c_last, d_last;

	// line rams
	logic          rd_en;
	logic [CW-1:0] rd_addr;
	rmf_pkg::rgb_t up_rd, lo_rd;
	logic          wr_en;

	// stage 1: item with its ram read data
	logic          s1_v, s1_pix, s1_drn;
	rmf_pkg::rgb_t s1_px;
	logic [CW-1:0] s1_col;
	logic          s1_e1, s1_e2, s1_lc1, s1_tr1, s1_first, s1_lastd;

	// window and drain column registers
	rmf_pkg::rgb_t win_q [9];
	rmf_pkg::rgb_t ncell [9];
	rmf_pkg::rgb_t up_prv_q, up_cur_q, lo_prv_q, lo_cur_q;
	rmf_pkg::rgb_t t0, t1, t2, uL, uR, lL, lR;
	rmf_pkg::win_t res1, res2, resd;

	// stage 2: up to two pending result windows
	rmf_pkg::win_t s2_a, s2_b;
	rmf_pkg::tag_t s2_ta, s2_tb;
	logic [1:0]    s2_cnt;

	// median network
	logic          med_ov;
	rmf_pkg::rgb_t med_px;
	rmf_pkg::tag_t med_tag;

	// clamp the frame size to at least two and to the maximum width and height
	always_comb begin
		wx = 32'(width_q);
		if (wx < 32'd2) begin
			wx = 32'd2;
		end else if (wx > 32'(MAX_WIDTH)) begin
			wx = 32'(MAX_WIDTH);
		end
		hx = 32'(height_q);
		if (hx < 32'd2) begin
			hx = 32'd2;
		end else if (hx > 32'(MAX_HEIGHT)) begin
			hx = 32'(MAX_HEIGHT);
		end
	end

	assign w_eff = wx[WW-1:0];
	assign w_m1  = w_eff - WW'(1);
	assign h_m1  = hx[HW-1:0] - HW'(1);

	// whole pipe stalls on a full output; two pending results block the front while the second is handed on
	assign go       = !med_ov || out_ready;
	assign up_adv   = go && (s2_cnt != 2'd2);
	assign in_ready = up_adv && (pf_q == PF_IDLE);
	assign acc      = in_valid && in_ready;
	assign is_pix   = (opcode == rmf_pkg::OP_PIXEL) && !flush_q;
	assign is_drn   = (opcode == rmf_pkg::OP_DRAIN) && flush_q;
	assign c_last   = (WW'(col_q) == w_m1);
	assign d_last   = (WW'(drn_q) == w_m1);

	// ram read: pixel column, next drain column (the current one at the last), or column 0 for the preload
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (pf_q == PF_WAIT && !s1_v) begin
			rd_en = 1'b1;
		end else if (acc) begin
			rd_en = 1'b1;
			if (is_drn) begin
				rd_addr = d_last ? drn_q : drn_q + CW'(1);
			end else begin
				rd_addr = col_q;
			end
		end
	end

	assign wr_en = up_adv && s1_v && s1_pix;

	rmf_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
		.clk   (clk),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (up_rd),
		.we    (wr_en),
		.waddr (s1_col),
		.wdata (lo_rd)
	);

	rmf_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lower (
		.clk   (clk),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (lo_rd),
		.we    (wr_en),
		.waddr (s1_col),
		.wdata (s1_px)
	);

	// configuration, frame position and preload sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rmf_pkg::WIDTH_REG_W'(rmf_pkg::RESET_WIDTH);
			height_q <= rmf_pkg::HEIGHT_REG_W'(rmf_pkg::RESET_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			drn_q    <= '0;
			flush_q  <= 1'b0;
			pf_q     <= PF_IDLE;
		end else begin
			unique case (pf_q)
				PF_WAIT: begin
					if (!s1_v) begin
						pf_q <= PF_LOAD;
					end
				end
				PF_LOAD: pf_q <= PF_IDLE;
				default: ;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					rmf_pkg::REG_WIDTH:  width_q  <= cfg_data[rmf_pkg::WIDTH_REG_W-1:0];
					rmf_pkg::REG_HEIGHT: height_q <= cfg_data[rmf_pkg::HEIGHT_REG_W-1:0];
					default: ;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				drn_q   <= '0;
				flush_q <= 1'b0;
			end else if (acc && is_pix) begin
				if (c_last) begin
					col_q <= '0;
					if (HW'(row_q) >= h_m1) begin
						// frame complete: preload, then drain the final row
						flush_q <= 1'b1;
						drn_q   <= '0;
						pf_q    <= PF_WAIT;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (acc && is_drn) begin
				if (d_last) begin
					col_q   <= '0;
					row_q   <= '0;
					drn_q   <= '0;
					flush_q <= 1'b0;
				end else begin
					drn_q <= drn_q + CW'(1);
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (up_adv) begin
			s1_v <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (up_adv) begin
			s1_pix   <= is_pix;
			s1_drn   <= is_drn;
			s1_px    <= {in_red, in_green, in_blue};
			s1_col   <= col_q;
			s1_e1    <= (row_q != '0) && (col_q != '0);
			s1_e2    <= (row_q != '0) && c_last;
			s1_lc1   <= (col_q == CW'(1));
			s1_tr1   <= (row_q == RW'(1));
			s1_first <= (drn_q == '0);
			s1_lastd <= d_last;
		end
	end

	// shifted window with the new column on the right
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ncell[i*3]   = win_q[i*3+1];
			ncell[i*3+1] = win_q[i*3+2];
			ncell[i*3+2] = win_q[i*3+2];
		end
		ncell[2] = up_rd;
		ncell[5] = lo_rd;
		ncell[8] = s1_px;
	end

	// on the second input row the bottom row reflects onto the top one
	assign t0 = s1_tr1 ? ncell[6] : ncell[0];
	assign t1 = s1_tr1 ? ncell[7] : ncell[1];
	assign t2 = s1_tr1 ? ncell[8] : ncell[2];

	// centered window; at input column one the right column reflects onto the left
	assign res1[0] = s1_lc1 ? t2 : t0;
	assign res1[1] = t1;
	assign res1[2] = t2;
	assign res1[3] = s1_lc1 ? ncell[5] : ncell[3];
	assign res1[4] = ncell[4];
	assign res1[5] = ncell[5];
	assign res1[6] = s1_lc1 ? ncell[8] : ncell[6];
	assign res1[7] = ncell[7];
	assign res1[8] = ncell[8];

	// last column of the row, right side reflected
	assign res2[0] = t1;
	assign res2[1] = t2;
	assign res2[2] = t1;
	assign res2[3] = ncell[4];
	assign res2[4] = ncell[5];
	assign res2[5] = ncell[4];
	assign res2[6] = ncell[7];
	assign res2[7] = ncell[8];
	assign res2[8] = ncell[7];

	// final row: bottom edge reflects the upper line
	assign uL = s1_first ? up_rd : up_prv_q;
	assign uR = s1_lastd ? up_prv_q : up_rd;
	assign lL = s1_first ? lo_rd : lo_prv_q;
	assign lR = s1_lastd ? lo_prv_q : lo_rd;
	assign resd[0] = uL;
	assign resd[1] = up_cur_q;
	assign resd[2] = uR;
	assign resd[3] = lL;
	assign resd[4] = lo_cur_q;
	assign resd[5] = lR;
	assign resd[6] = uL;
	assign resd[7] = up_cur_q;
	assign resd[8] = uR;

	// window and drain columns
	always_ff @(posedge clk) begin
		if (pf_q == PF_LOAD) begin
			up_cur_q <= up_rd;
			lo_cur_q <= lo_rd;
		end else if (up_adv && s1_v && s1_drn) begin
			up_prv_q <= up_cur_q;
			lo_prv_q <= lo_cur_q;
			up_cur_q <= up_rd;
			lo_cur_q <= lo_rd;
		end
		if (up_adv && s1_v && s1_pix) begin
			win_q <= ncell;
		end
	end

	// stage 2: hand pending windows to the median network one per clock while the output does not stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_cnt <= 2'd0;
		end else if (go) begin
			if (s2_cnt == 2'd2) begin
				s2_cnt <= 2'd1;
			end else if (s1_v && s1_pix) begin
				s2_cnt <= s1_e2 ? 2'd2 : (s1_e1 ? 2'd1 : 2'd0);
			end else if (s1_v && s1_drn) begin
				s2_cnt <= 2'd1;
			end else begin
				s2_cnt <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (s2_cnt == 2'd2) begin
				s2_a  <= s2_b;
				s2_ta <= s2_tb;
			end else if (s1_drn) begin
				s2_a  <= resd;
				s2_ta <= '{run_last: 1'b1, frame_last: s1_lastd};
			end else begin
				s2_a  <= res1;
				s2_ta <= '{run_last: !s1_e2, frame_last: 1'b0};
				s2_b  <= res2;
				s2_tb <= '{run_last: 1'b1, frame_last: 1'b0};
			end
		end
	end

	rmf_median9 u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (go),
		.in_valid  (s2_cnt != 2'd0),
		.win       (s2_a),
		.in_tag    (s2_ta),
		.out_valid (med_ov),
		.out_px    (med_px),
		.out_tag   (med_tag)
	);

	assign out_valid  = med_ov;
	assign out_red    = med_px[23:16];
	assign out_green  = med_px[15:8];
	assign out_blue   = med_px[7:0];
	assign run_last   = med_tag.run_last;
	assign frame_last = med_tag.frame_last;

endmodule
`default_nettype wire
